/* sv/tlpq_pkg.sv */
package tlpq_pkg;

  // Result status codes carried on the result channel.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADPRI = 2'd1,
    ST_FULL  = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  // Request kind codes carried on the request channel.
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Per-cycle commands from the controller to one level cell.
  typedef struct packed {
    logic enq;   // append the write data to this level
    logic deq;   // a dequeue request is being accepted
  } cell_ctl_t;

  // Status reported by one level cell.
  typedef struct packed {
    logic full;      // level holds DEPTH entries
    logic nonempty;  // level holds at least one entry
    logic serve;     // this level serves the current dequeue
  } cell_stat_t;

endpackage

/* sv/tlpq_cell.sv */
module tlpq_cell import tlpq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  taken_in,
  output logic                  taken_out,
  output cell_stat_t            stat,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      count;
  logic                  do_wr;
  logic                  do_rd;

  assign stat.full     = (count == FULL_CNT);
  assign stat.nonempty = (count != '0);
  assign do_wr         = ctl.enq && !stat.full;
  assign do_rd         = ctl.deq && !taken_in && stat.nonempty;
  assign stat.serve    = do_rd;
  // A dequeue is claimed by the first non-empty level down the chain.
  assign taken_out     = taken_in || stat.nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      end
      if (do_rd) begin
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[tail] <= wr_data;
    end
    if (do_rd) begin
      rd_data <= mem[head];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("level count above depth");
  a_full_refuses: assert property (@(posedge clk) disable iff (rst)
      stat.full && ctl.enq && !do_rd |=> stat.full)
    else $error("full level changed on refused enqueue");

endmodule

/* sv/three_level_priority_queue.sv */
// Strict-priority queue with LEVELS first-in first-out levels, level 1 highest.
// Requests arrive on the s_ channel: s_tuser is the kind (0 enqueue, 1 dequeue),
// s_tdata carries the value and the priority. Every request produces exactly
// one result on the m_ channel: m_tuser is the status (0 ok, 1 bad priority,
// 2 level full, 3 underflow), m_tdata carries the popped value and the level.
// The levels form a chain of cells; a dequeue passes down the chain and is
// claimed by the first non-empty level.
// For each request, in the accept cycle the level pointers move and the level
// store is read; once the output register is free, the result is moved into it.
// s_tready is low from the accept until that move, so the block does not take a
// new request before the result of the last one has left the pending register.
// When the receiver stalls, the result waits in the output register, the next
// request is still accepted, and its result waits in the internal pending
// register until the output register frees up.
// Reset empties all levels and clears both channels at once; the store
// contents themselves are not cleared and need no clearing pass.
module three_level_priority_queue import tlpq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int LEVELS     = 3,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // value [31:0], priority_req [34:32], zero pad
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // popped_value [31:0], served_level [33:32], zero pad
  output logic [1:0]  m_tuser   // status
);

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic                  accept;
  logic                  is_enq;
  logic                  pri_ok;
  logic [2:0]            pri;
  logic signed [31:0]    in_value;
  logic [DATA_WIDTH-1:0] wr_data;

  cell_ctl_t             ctl   [LEVELS];
  cell_stat_t            stat  [LEVELS];
  logic [DATA_WIDTH-1:0] rd    [LEVELS];
  logic [LEVELS:0]       taken;
  logic [LEVELS-1:0]     serve_vec;
  logic [LEVELS-1:0]     full_vec;
  logic [LEVELS-1:0]     sel_vec;

  logic                  full_hit;
  logic [LVL_W-1:0]      serve_idx;
  logic [1:0]            serve_level;

  // Request in flight between accept and the output register.
  logic                  busy;
  status_t               p_status;
  logic [1:0]            p_level;
  logic [LVL_W-1:0]      p_sel;
  logic                  p_pop;

  status_t               status_next;
  logic [1:0]            level_next;
  logic [31:0]           pop_value;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign is_enq   = (s_tuser == KIND_ENQ);
  assign in_value = s_tdata[31:0];
  assign pri      = s_tdata[34:32];
  assign pri_ok   = (pri != 3'd0) && (32'(pri) <= 32'(LEVELS));
  // The stored word is the value sign-extended or cut to the store width.
  assign wr_data  = DATA_WIDTH'(in_value);

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    assign sel_vec[i] = pri_ok && (32'(pri) == 32'(i + 1));
    assign ctl[i].enq = accept && is_enq && sel_vec[i];
    assign ctl[i].deq = accept && !is_enq;
    assign serve_vec[i] = stat[i].serve;
    assign full_vec[i]  = stat[i].full;

    tlpq_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .wr_data   (wr_data),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .stat      (stat[i]),
      .rd_data   (rd[i])
    );
  end

  assign full_hit = |(sel_vec & full_vec);

  always_comb begin
    serve_idx   = '0;
    serve_level = 2'd0;
    for (int i = 0; i < LEVELS; i++) begin
      if (serve_vec[i]) begin
        serve_idx   = LVL_W'(i);
        serve_level = 2'(i + 1);
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    level_next  = 2'd0;
    if (is_enq) begin
      priority if (!pri_ok) begin
        status_next = ST_BADPRI;
      end else if (full_hit) begin
        status_next = ST_FULL;
      end else begin
        level_next = pri[1:0];
      end
    end else begin
      if (taken[LEVELS]) begin
        level_next = serve_level;
      end else begin
        status_next = ST_UNDER;
      end
    end
  end

  // The popped word is shown zero-extended or cut to 32 bits.
  assign pop_value = p_pop ? 32'(rd[p_sel]) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (busy && (!m_tvalid || m_tready)) begin
        busy <= 1'b0;
      end
      if (busy && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= status_next;
      p_level  <= level_next;
      p_sel    <= serve_idx;
      p_pop    <= !is_enq && taken[LEVELS];
    end
    if (busy && (!m_tvalid || m_tready)) begin
      m_tuser <= p_status;
      m_tdata <= {6'd0, p_level, pop_value};
    end
  end

  a_one_server: assert property (@(posedge clk) disable iff (rst) $onehot0(serve_vec))
    else $error("more than one level served a dequeue");
  a_deq_served: assert property (@(posedge clk) disable iff (rst)
      accept && !is_enq && taken[LEVELS] |=> p_status == ST_OK && p_pop)
    else $error("dequeue with stored entries was not served");
  a_busy_drains: assert property (@(posedge clk) disable iff (rst)
      busy && !m_tvalid |=> !busy && m_tvalid)
    else $error("pending result not moved to free output register");
  a_enq_no_pop: assert property (@(posedge clk) disable iff (rst)
      accept && is_enq |=> !p_pop)
    else $error("enqueue marked as popping a value");

endmodule
